// ===== sv/nps_pkg.sv =====
// ----------------------------------------------------------------------------
// nps_pkg: shared definitions for the priority scheduler
// Sizes, command codes and the control/status bundles passed between the
// scheduler controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

  // Table and field sizes
  localparam int SLOTS     = 16;
  localparam int SLOT_BITS = 4;
  localparam int TIME_BITS = 16;
  localparam int PRIO_BITS = 8;
  localparam int COMP_BITS = TIME_BITS + 1;
  localparam int WAIT_BITS = TIME_BITS + 2;

  // Input command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic                 load;        // write input beat into its slot
    logic                 tick_start;  // latch now, clear best candidate
    logic                 scan;        // compare slot scan_idx with best
    logic [SLOT_BITS-1:0] scan_idx;
    logic                 update;      // run target slot for one unit
    logic                 emit;        // load the output register
    logic                 emit_idle;   // result is an idle tick
  } nps_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic run_act;   // a slot holds the processor
    logic found;     // scan found an eligible slot
    logic out_free;  // output register can take a beat
  } nps_stat_t;

endpackage

`default_nettype wire

// ===== sv/nps_if.sv =====
// ----------------------------------------------------------------------------
// nps_in_if / nps_out_if: valid/ready channels of the priority scheduler
// A beat moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface nps_in_if;
  import nps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [SLOT_BITS-1:0] slot;
  logic [TIME_BITS-1:0] arrival_time;
  logic [TIME_BITS-1:0] burst_time;
  logic [PRIO_BITS-1:0] priority_level;
  logic [TIME_BITS-1:0] now;

  modport source (output valid, cmd, slot, arrival_time, burst_time, priority_level, now,
                  input ready);
  modport sink   (input valid, cmd, slot, arrival_time, burst_time, priority_level, now,
                  output ready);
endinterface

interface nps_out_if;
  import nps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 idle;
  logic [SLOT_BITS-1:0] run_slot;
  logic [TIME_BITS-1:0] time_left;
  logic                 finished;
  logic [COMP_BITS-1:0] completion_time;
  logic [COMP_BITS-1:0] turnaround;
  logic signed [WAIT_BITS-1:0] waiting;

  modport source (output valid, idle, run_slot, time_left, finished, completion_time,
                  turnaround, waiting, input ready);
  modport sink   (input valid, idle, run_slot, time_left, finished, completion_time,
                  turnaround, waiting, output ready);
endinterface

`default_nettype wire

// ===== sv/nps_ctrl.sv =====
// ----------------------------------------------------------------------------
// nps_ctrl: scheduler sequencer
// Accepts beats; a tick walks the slot table one slot a cycle unless a slot
// holds the processor, then runs the chosen slot and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_ctrl
  import nps_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_cmd,
  output logic           in_ready,
  output nps_cmd_t       cmd,
  input  wire nps_stat_t stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [SLOT_BITS-1:0] cnt_r, cnt_nxt;
  logic                 idle_r, idle_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idle_nxt  = idle_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.scan_idx  = cnt_r;
    cmd.emit_idle = idle_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_TICK) begin
            cmd.tick_start = 1'b1;
            cnt_nxt        = '0;
            state_nxt      = stat.run_act ? S_UPD : S_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == SLOT_BITS'(SLOTS - 1)) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        // Run the holding slot or the scan winner; otherwise report idle
        cmd.update = stat.run_act | stat.found;
        idle_nxt   = ~(stat.run_act | stat.found);
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idle_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idle_r  <= idle_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/nps_dp.sv =====
// ----------------------------------------------------------------------------
// nps_dp: scheduler datapath
// Slot table, one compare unit for the priority scan, the run/update
// arithmetic and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_dp
  import nps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire nps_cmd_t             cmd,
  output nps_stat_t                 stat,
  // input beat payload
  input  wire logic [SLOT_BITS-1:0] in_slot,
  input  wire logic [TIME_BITS-1:0] in_arrival_time,
  input  wire logic [TIME_BITS-1:0] in_burst_time,
  input  wire logic [PRIO_BITS-1:0] in_priority_level,
  input  wire logic [TIME_BITS-1:0] in_now,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_idle,
  output logic [SLOT_BITS-1:0]      out_run_slot,
  output logic [TIME_BITS-1:0]      out_time_left,
  output logic                      out_finished,
  output logic [COMP_BITS-1:0]      out_completion_time,
  output logic [COMP_BITS-1:0]      out_turnaround,
  output logic signed [WAIT_BITS-1:0] out_waiting
);

  // Slot table
  logic [SLOTS-1:0]     valid_r;
  logic [TIME_BITS-1:0] arr_r   [SLOTS];
  logic [TIME_BITS-1:0] burst_r [SLOTS];
  logic [PRIO_BITS-1:0] prio_r  [SLOTS];
  logic [TIME_BITS-1:0] rem_r   [SLOTS];

  // Running process
  logic                 run_act_r;
  logic [SLOT_BITS-1:0] run_slot_r;

  // Tick context and best candidate
  logic [TIME_BITS-1:0] now_r;
  logic                 best_found_r;
  logic [SLOT_BITS-1:0] best_idx_r;
  logic [PRIO_BITS-1:0] best_prio_r;
  logic [TIME_BITS-1:0] best_arr_r;

  // Results of the update step
  logic [SLOT_BITS-1:0] res_slot_r;
  logic [TIME_BITS-1:0] res_rem_r;
  logic [COMP_BITS-1:0] res_comp_r;
  logic [COMP_BITS-1:0] res_turn_r;
  logic [TIME_BITS-1:0] res_burst_r;

  // Output register
  logic                 out_valid_r;
  logic                 out_idle_r;
  logic [SLOT_BITS-1:0] out_slot_r;
  logic [TIME_BITS-1:0] out_left_r;
  logic                 out_fin_r;
  logic [COMP_BITS-1:0] out_comp_r;
  logic [COMP_BITS-1:0] out_turn_r;
  logic [WAIT_BITS-1:0] out_wait_r;

  // Single read port: scan index while scanning, run target otherwise
  logic [SLOT_BITS-1:0] tgt;
  logic [SLOT_BITS-1:0] rd_addr;
  logic [TIME_BITS-1:0] rd_arr, rd_burst, rd_rem;
  logic [PRIO_BITS-1:0] rd_prio;
  logic                 rd_valid;

  assign tgt      = run_act_r ? run_slot_r : best_idx_r;
  assign rd_addr  = cmd.scan ? cmd.scan_idx : tgt;
  assign rd_valid = valid_r[rd_addr];
  assign rd_arr   = arr_r[rd_addr];
  assign rd_burst = burst_r[rd_addr];
  assign rd_prio  = prio_r[rd_addr];
  assign rd_rem   = rem_r[rd_addr];

  // Compare unit: eligible and better than the current best
  logic elig, better;
  assign elig   = rd_valid && (rd_arr <= now_r) && (rd_rem != '0);
  assign better = !best_found_r || (rd_prio < best_prio_r) ||
                  ((rd_prio == best_prio_r) && (rd_arr < best_arr_r));

  // Update arithmetic
  logic [TIME_BITS-1:0] rem_new;
  logic [COMP_BITS-1:0] comp;
  logic [WAIT_BITS-1:0] turn_diff;
  logic [WAIT_BITS-1:0] wait_val;

  assign rem_new   = rd_rem - 1'b1;
  assign comp      = {1'b0, now_r} + 1'b1;
  assign turn_diff = {1'b0, comp} - {2'b00, rd_arr};
  assign wait_val  = {1'b0, res_turn_r} - {2'b00, res_burst_r};

  // Slot table writes; slot field width covers exactly SLOTS entries
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      arr_r[in_slot]   <= in_arrival_time;
      burst_r[in_slot] <= in_burst_time;
      prio_r[in_slot]  <= in_priority_level;
      rem_r[in_slot]   <= in_burst_time;
    end else if (cmd.update) begin
      rem_r[tgt] <= rem_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      run_act_r <= 1'b0;
    end else if (cmd.load) begin
      valid_r[in_slot] <= 1'b1;
      // reloading the running slot drops its hold on the processor
      if (run_act_r && (run_slot_r == in_slot)) begin
        run_act_r <= 1'b0;
      end
    end else if (cmd.update) begin
      run_act_r <= (rem_new != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      run_slot_r <= tgt;
    end
  end

  // Tick context and best-candidate tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
    end else if (cmd.tick_start) begin
      best_found_r <= 1'b0;
    end else if (cmd.scan && elig && better) begin
      best_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      now_r <= in_now;
    end
    if (cmd.scan && elig && better) begin
      best_idx_r  <= cmd.scan_idx;
      best_prio_r <= rd_prio;
      best_arr_r  <= rd_arr;
    end
  end

  // Capture update results; turnaround saturates at zero
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_slot_r  <= tgt;
      res_rem_r   <= rem_new;
      res_comp_r  <= comp;
      res_turn_r  <= turn_diff[WAIT_BITS-1] ? '0 : turn_diff[COMP_BITS-1:0];
      res_burst_r <= rd_burst;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.emit_idle) begin
        out_idle_r <= 1'b1;
        out_slot_r <= '0;
        out_left_r <= '0;
        out_fin_r  <= 1'b0;
        out_comp_r <= '0;
        out_turn_r <= '0;
        out_wait_r <= '0;
      end else begin
        out_idle_r <= 1'b0;
        out_slot_r <= res_slot_r;
        out_left_r <= res_rem_r;
        out_fin_r  <= (res_rem_r == '0);
        if (res_rem_r == '0) begin
          out_comp_r <= res_comp_r;
          out_turn_r <= res_turn_r;
          out_wait_r <= wait_val;
        end else begin
          out_comp_r <= '0;
          out_turn_r <= '0;
          out_wait_r <= '0;
        end
      end
    end
  end

  assign stat.run_act  = run_act_r;
  assign stat.found    = best_found_r;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_idle            = out_idle_r;
  assign out_run_slot        = out_slot_r;
  assign out_time_left       = out_left_r;
  assign out_finished        = out_fin_r;
  assign out_completion_time = out_comp_r;
  assign out_turnaround      = out_turn_r;
  assign out_waiting         = out_wait_r;

endmodule

`default_nettype wire

// ===== sv/nonpreemptive_priority_scheduler.sv =====
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler: slot-table priority scheduler
// A load beat writes one process slot; a tick beat yields one result beat.
// ----------------------------------------------------------------------------
// A load beat is taken while the controller is idle and returns nothing. A tick
// beat returns one beat: when a process already holds the processor it runs
// through accept, update and result; otherwise a single compare unit walks the
// 16-entry slot table one slot per cycle before the update and result. Lowest
// priority number wins, ties go to the earlier arrival and then to the lower
// slot. The next beat is taken once the tick result sits in the output register,
// even if the sink has not yet taken it.
`default_nettype none

module nonpreemptive_priority_scheduler
  import nps_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  nps_in_if.sink   in_ch,
  nps_out_if.source out_ch
);

  nps_cmd_t  cmd;
  nps_stat_t stat;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  nps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  nps_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_slot             (in_ch.slot),
    .in_arrival_time     (in_ch.arrival_time),
    .in_burst_time       (in_ch.burst_time),
    .in_priority_level   (in_ch.priority_level),
    .in_now              (in_ch.now),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_idle            (out_ch.idle),
    .out_run_slot        (out_ch.run_slot),
    .out_time_left       (out_ch.time_left),
    .out_finished        (out_ch.finished),
    .out_completion_time (out_ch.completion_time),
    .out_turnaround      (out_ch.turnaround),
    .out_waiting         (out_ch.waiting)
  );

endmodule

`default_nettype wire

// ===== bench/tb_nonpreemptive_priority_scheduler.sv =====
// ----------------------------------------------------------------------------
// tb_nonpreemptive_priority_scheduler: self-checking bench for the scheduler
// Loads process slots and issues scheduling ticks over the valid/ready input
// channel. It mirrors the slot table to predict every tick report, and it
// compares each report beat against the oldest prediction. A directed opening
// covers tie breaks, zero bursts, reloads of a running slot, time running
// backwards and field extremes. Random scenarios follow: batches of loads
// followed by runs of ticks, with some noise.
// ----------------------------------------------------------------------------
module tb_nonpreemptive_priority_scheduler;
  import nps_pkg::*;

  localparam int ITEM_TARGET = 800;
  localparam int BIG_BURST   = 40;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic                 cmd;
    logic [SLOT_BITS-1:0] slot;
    logic [TIME_BITS-1:0] arrival_time;
    logic [TIME_BITS-1:0] burst_time;
    logic [PRIO_BITS-1:0] prio_level;
    logic [TIME_BITS-1:0] now;
  } sched_req_t;

  typedef struct packed {
    logic                 idle;
    logic [SLOT_BITS-1:0] run_slot;
    logic [TIME_BITS-1:0] time_left;
    logic                 finished;
    logic [COMP_BITS-1:0] completion_time;
    logic [COMP_BITS-1:0] turnaround;
    logic [WAIT_BITS-1:0] waiting;
  } sched_res_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  nps_in_if  in_ch ();
  nps_out_if out_ch ();

  nonpreemptive_priority_scheduler uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // Stimulus and expected tick reports
  sched_req_t cmd_stream[$];
  sched_res_t tick_reports[$];
  logic       gen_dirty[SLOTS];
  int         total_beats;

  // Mirror of the slot table
  logic                 slot_live[SLOTS];
  logic                 slot_busy[SLOTS];
  logic [TIME_BITS-1:0] slot_arr[SLOTS];
  logic [TIME_BITS-1:0] slot_len[SLOTS];
  logic [TIME_BITS-1:0] slot_left[SLOTS];
  logic [PRIO_BITS-1:0] slot_prio[SLOTS];

  // Run statistics
  logic in_took;
  int   beats_taken;
  int   loads_taken;
  int   ticks_taken;
  int   reports_seen;
  int   finishes_seen;
  int   idles_seen;
  int   mismatches;
  int   fail_count;

  // Run slot s for one time unit and build its report
  function automatic sched_res_t serve_one_unit(int s, logic [TIME_BITS-1:0] t);
    sched_res_t           r;
    logic [COMP_BITS-1:0] comp;
    logic [COMP_BITS-1:0] turn;
    r = '0;
    slot_busy[s] = 1'b1;
    slot_left[s] = slot_left[s] - 1'b1;
    r.run_slot   = s[SLOT_BITS-1:0];
    r.time_left  = slot_left[s];
    if (slot_left[s] == '0) begin
      slot_busy[s] = 1'b0;
      comp = {1'b0, t} + 1'b1;
      turn = (comp >= {1'b0, slot_arr[s]}) ? comp - {1'b0, slot_arr[s]} : '0;
      r.finished        = 1'b1;
      r.completion_time = comp;
      r.turnaround      = turn;
      r.waiting         = {1'b0, turn} - {2'b00, slot_len[s]};
    end
    return r;
  endfunction

  // Apply one accepted beat to the mirror; a tick queues its report
  function automatic void schedule_beat(sched_req_t b);
    sched_res_t r;
    int         pick;
    pick = -1;
    if (b.cmd == CMD_LOAD) begin
      slot_live[b.slot] = 1'b1;
      slot_busy[b.slot] = 1'b0;
      slot_arr[b.slot]  = b.arrival_time;
      slot_len[b.slot]  = b.burst_time;
      slot_left[b.slot] = b.burst_time;
      slot_prio[b.slot] = b.prio_level;
      return;
    end
    // a running slot keeps the processor; drop stale running marks
    for (int i = 0; i < SLOTS; i++) begin
      if (pick < 0 && slot_live[i] && slot_busy[i]) begin
        if (slot_left[i] != '0) pick = i;
        else slot_busy[i] = 1'b0;
      end
    end
    if (pick >= 0) begin
      tick_reports.push_back(serve_one_unit(pick, b.now));
      return;
    end
    // pick lowest priority number, then earlier arrival, then lower slot
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i] && slot_arr[i] <= b.now && slot_left[i] != '0) begin
        if (pick < 0) begin
          pick = i;
        end else if (slot_prio[i] < slot_prio[pick] ||
                     (slot_prio[i] == slot_prio[pick] && slot_arr[i] < slot_arr[pick])) begin
          pick = i;
        end
      end
    end
    if (pick < 0) begin
      r = '0;
      r.idle = 1'b1;
      tick_reports.push_back(r);
    end else begin
      tick_reports.push_back(serve_one_unit(pick, b.now));
    end
  endfunction

  task automatic push_load(int s, int arr, int len, int prio);
    sched_req_t b;
    b.cmd            = CMD_LOAD;
    b.slot           = s[SLOT_BITS-1:0];
    b.arrival_time   = (arr > 65535) ? 16'hffff : arr[TIME_BITS-1:0];
    b.burst_time     = len[TIME_BITS-1:0];
    b.prio_level     = prio[PRIO_BITS-1:0];
    b.now            = TIME_BITS'($urandom_range(0, 65535));
    gen_dirty[s]     = (len > BIG_BURST);
    cmd_stream.push_back(b);
  endtask

  task automatic push_tick(int t);
    sched_req_t b;
    b.cmd            = CMD_TICK;
    b.slot           = SLOT_BITS'($urandom_range(0, SLOTS - 1));
    b.arrival_time   = TIME_BITS'($urandom_range(0, 65535));
    b.burst_time     = TIME_BITS'($urandom_range(0, 65535));
    b.prio_level     = PRIO_BITS'($urandom_range(0, 255));
    b.now            = (t > 65535) ? 16'hffff : t[TIME_BITS-1:0];
    cmd_stream.push_back(b);
  endtask

  // Drive input beats at the falling edge; hold a beat until it is taken
  always @(negedge clk) begin : drive_in
    sched_req_t nxt;
    int         gap_pct;
    gap_pct = (beats_taken < total_beats / 3) ? 22 :
              (beats_taken < 2 * total_beats / 3) ? 52 : 0;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (cmd_stream.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
        nxt = cmd_stream.pop_front();
        in_ch.cmd            <= nxt.cmd;
        in_ch.slot           <= nxt.slot;
        in_ch.arrival_time   <= nxt.arrival_time;
        in_ch.burst_time     <= nxt.burst_time;
        in_ch.priority_level <= nxt.prio_level;
        in_ch.now            <= nxt.now;
        in_ch.valid          <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Stall the report channel at random
  always @(negedge clk) begin : drive_ready
    int stall_pct;
    stall_pct = (beats_taken < total_beats / 3) ? 52 :
                (beats_taken < 2 * total_beats / 3) ? 22 : 0;
    out_ch.ready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
  end

  // Check report beats, then predict from accepted input beats
  always @(posedge clk) begin : watch
    sched_req_t got_req;
    sched_res_t got;
    sched_res_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        got.idle            = out_ch.idle;
        got.run_slot        = out_ch.run_slot;
        got.time_left       = out_ch.time_left;
        got.finished        = out_ch.finished;
        got.completion_time = out_ch.completion_time;
        got.turnaround      = out_ch.turnaround;
        got.waiting         = out_ch.waiting;
        reports_seen++;
        if (got.finished === 1'b1) finishes_seen++;
        if (got.idle === 1'b1) idles_seen++;
        if (tick_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected report beat at %0t: idle=%0d slot=%0d", $realtime,
                     got.idle, got.run_slot);
        end else begin
          want = tick_reports.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("report mismatch at %0t", $realtime);
              $display("  expected idle=%0d slot=%0d left=%0d fin=%0d comp=%0d turn=%0d wait=%0d",
                       want.idle, want.run_slot, want.time_left, want.finished,
                       want.completion_time, want.turnaround, $signed(want.waiting));
              $display("  actual   idle=%0d slot=%0d left=%0d fin=%0d comp=%0d turn=%0d wait=%0d",
                       got.idle, got.run_slot, got.time_left, got.finished,
                       got.completion_time, got.turnaround, $signed(got.waiting));
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        got_req.cmd          = in_ch.cmd;
        got_req.slot         = in_ch.slot;
        got_req.arrival_time = in_ch.arrival_time;
        got_req.burst_time   = in_ch.burst_time;
        got_req.prio_level   = in_ch.priority_level;
        got_req.now          = in_ch.now;
        beats_taken++;
        if (got_req.cmd == CMD_LOAD) loads_taken++;
        else ticks_taken++;
        schedule_beat(got_req);
      end
    end
  end

  // Build the stimulus, run it and judge the result
  initial begin : run_main
    int base;
    int t_now;
    int span;
    int len;
    int prio;
    int s;
    in_ch.valid          = 1'b0;
    in_ch.cmd            = CMD_LOAD;
    in_ch.slot           = '0;
    in_ch.arrival_time   = '0;
    in_ch.burst_time     = '0;
    in_ch.priority_level = '0;
    in_ch.now            = '0;
    out_ch.ready         = 1'b0;
    in_took       = 1'b0;
    beats_taken   = 0;
    loads_taken   = 0;
    ticks_taken   = 0;
    reports_seen  = 0;
    finishes_seen = 0;
    idles_seen    = 0;
    mismatches    = 0;
    total_beats   = ITEM_TARGET;
    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_busy[i] = 1'b0;
      gen_dirty[i] = 1'b0;
    end

    // empty table gives an idle tick
    push_tick(0);
    // zero burst never runs; slot 15 holds the field maxima
    push_load(0, 0, 0, 0);
    push_load(15, 65535, 65535, 255);
    // equal priorities: earlier arrival first, then lower slot
    push_load(3, 5, 2, 7);
    push_load(9, 5, 1, 7);
    push_load(6, 4, 1, 7);
    push_tick(3);
    push_tick(5);
    push_tick(6);
    // a better priority arriving does not take over the running slot
    push_load(2, 0, 1, 0);
    push_tick(7);
    push_tick(8);
    push_tick(9);
    // running slot keeps going while time steps backwards; turnaround floors at zero
    push_load(4, 60000, 2, 1);
    push_tick(60000);
    push_tick(10);
    // reloading a running slot drops its running mark
    push_load(1, 0, 3, 0);
    push_load(7, 0, 1, 1);
    push_tick(100);
    push_load(1, 0, 1, 2);
    push_tick(101);
    // completion at the top of the time range
    push_load(5, 0, 1, 0);
    push_tick(65535);
    push_tick(65535);
    push_tick(65535);

    // random scenarios: fresh loads then a run of ticks, plus some noise
    while (cmd_stream.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 0) begin
            len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 8);
            push_load($urandom_range(0, SLOTS - 1), $urandom_range(0, 65535), len,
                      $urandom_range(0, 255));
          end else begin
            push_tick($urandom_range(0, 65535));
          end
        end
      end else begin
        base = $urandom_range(0, 65000);
        // retire long-running leftovers so they do not hog every tick
        for (int i = 0; i < SLOTS; i++)
          if (gen_dirty[i]) push_load(i, $urandom_range(0, 65535), 0, $urandom_range(0, 255));
        span = 0;
        repeat ($urandom_range(1, 6)) begin
          s    = $urandom_range(0, SLOTS - 1);
          len  = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
          prio = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 255);
          push_load(s, base + $urandom_range(0, 8), len, prio);
          span += len;
        end
        t_now = base;
        repeat (span + $urandom_range(0, 3)) begin
          case ($urandom_range(0, 19))
            0: t_now += $urandom_range(2, 20);
            1: t_now += 0;
            2: begin
              push_load($urandom_range(0, SLOTS - 1), t_now + $urandom_range(0, 3),
                        $urandom_range(1, 4), $urandom_range(0, 3));
              t_now += 1;
            end
            default: t_now += 1;
          endcase
          push_tick(t_now);
        end
      end
    end
    total_beats = cmd_stream.size();

    // hold reset, release it at a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    wait (beats_taken == total_beats);
    for (int c = 0; c < DRAIN_LIMIT && tick_reports.size() != 0; c++) @(posedge clk);
    repeat (40) @(posedge clk);

    fail_count = mismatches + tick_reports.size();
    if (tick_reports.size() != 0)
      $display("%0d tick reports never arrived", tick_reports.size());
    $display("ran %0d loads and %0d ticks; %0d reports, %0d completions, %0d idle ticks",
             loads_taken, ticks_taken, reports_seen, finishes_seen, idles_seen);
    $display("%0d report mismatches", mismatches);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin : watchdog
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/nps_pkg.sv
sv/nps_if.sv
sv/nps_ctrl.sv
sv/nps_dp.sv
sv/nonpreemptive_priority_scheduler.sv
bench/tb_nonpreemptive_priority_scheduler.sv
